/* rtl/first_fit_heap_allocator_top_macros.svh */
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Checks that hold in the same cycle as the condition.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that hold in the cycle after the condition.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ffha_pkg.sv */
package ffha_pkg;
	localparam int REQ_W  = 16;
	localparam int NEED_W = REQ_W - 2;
	localparam int FA_W   = 10;
	localparam int ADDR_W = 10;
	localparam int ST_W   = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_NULL    = 2'd2;
endpackage

/* rtl/ffha_req_if.sv */
interface ffha_req_if import ffha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [REQ_W-1:0] req_size;
	logic [FA_W-1:0]  free_addr;

	modport source (output valid, output cmd, output req_size, output free_addr, input ready);
	modport sink (input valid, input cmd, input req_size, input free_addr, output ready);
endinterface

/* rtl/ffha_rsp_if.sv */
interface ffha_rsp_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ADDR_W-1:0] addr;

	modport source (output valid, output status, output addr, input ready);
	modport sink (input valid, input status, input addr, output ready);
endinterface

/* rtl/ffha_ram.sv */
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// Alloc: the walk reads headers from the heap start until the k-th one fits, then writes
// the header; a walk that leaves the heap after k headers ends in no space.
// Free: a null address answers with no walk, any other after a walk over n headers, which
// it reads one per cycle. A waiting result holds the block until it is taken.
// The block is ready for the next item in the cycle after the result loads.
// Reset (arst_n low) makes the whole heap one free block at once; no clearing pass is run.
`include "first_fit_heap_allocator_top_macros.svh"

module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int HEAP_BYTES = 1024
) (
	input logic         clk,
	input logic         arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);
	localparam int NGRAN = HEAP_BYTES / 4;
	localparam int GW    = $clog2(NGRAN);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AW   = 3'd1;
	localparam logic [2:0] S_AS   = 3'd2;
	localparam logic [2:0] S_FM   = 3'd3;
	localparam logic [2:0] S_F0   = 3'd4;
	localparam logic [2:0] S_FG   = 3'd5;
	localparam logic [2:0] S_FN   = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	localparam logic [GW:0]   NGRAN_X = (GW + 1)'(NGRAN);
	localparam logic [GW-1:0] TOP_SZ  = GW'(NGRAN - 1);

	logic [2:0]        state_q, state_d;
	logic [GW-1:0]     g_q, g_d, nx_q, nx_d, gsz_q, gsz_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic              split_q, split_d;
	logic [GW-1:0]     h_q, h_d;
	logic              hv_q, hv_d;
	logic [ST_W-1:0]   res_st_q, res_st_d;
	logic [ADDR_W-1:0] res_addr_q, res_addr_d;
	logic              rsp_valid_q;
	logic [ST_W-1:0]   rsp_st_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic              sz0_q, fr0_q;
	logic              ld_out;

	logic [GW-1:0] rd_addr, ra_s1;
	logic          sz_we, fr_we, fr_wd;
	logic [GW-1:0] sz_wa, sz_wd, fr_wa;
	logic [GW-1:0] sz_raw, sz_rd;
	logic          fr_raw, fr_rd;

	logic [GW:0]       g1, nxt_a, nb, nx_m, nxt_n;
	logic [GW-1:0]     merged;
	logic [REQ_W-1:0]  szx, need16, rsum;
	logic              hit, split;
	logic [FA_W-3:0]   a8, h8;

	ffha_ram #(.WIDTH(GW), .DEPTH(NGRAN)) u_size_ram (
		.clk   (clk),
		.we    (sz_we),
		.waddr (sz_wa),
		.wdata (sz_wd),
		.raddr (rd_addr),
		.rdata (sz_raw)
	);

	ffha_ram #(.WIDTH(1), .DEPTH(NGRAN)) u_free_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_wa),
		.wdata (fr_wd),
		.raddr (rd_addr),
		.rdata (fr_raw)
	);

	assign sz_rd = (ra_s1 == '0 && sz0_q) ? TOP_SZ : sz_raw;
	assign fr_rd = (ra_s1 == '0 && fr0_q) ? 1'b1 : fr_raw;

	assign g1     = {1'b0, g_q} + (GW + 1)'(1);
	assign nxt_a  = g1 + {1'b0, sz_rd};
	assign merged = gsz_q + GW'(1) + sz_rd;
	assign nx_m   = g1 + {1'b0, merged};
	assign nxt_n  = {1'b0, nx_q} + (GW + 1)'(1) + {1'b0, sz_rd};

	assign szx    = REQ_W'(sz_rd);
	assign need16 = REQ_W'(need_q);
	assign hit    = fr_rd && (szx >= need16);
	assign split  = szx >= (need16 + REQ_W'(2));
	assign nb     = g1 + (GW + 1)'(need_q);

	assign rsum = req.req_size + REQ_W'(3);
	assign a8   = req.free_addr[FA_W-1:2];
	assign h8   = a8 - (FA_W - 2)'(1);

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_st_q;
	assign rsp.addr   = rsp_addr_q;

	always_comb begin
		state_d    = state_q;
		g_d        = g_q;
		nx_d       = nx_q;
		gsz_d      = gsz_q;
		need_d     = need_q;
		split_d    = split_q;
		h_d        = h_q;
		hv_d       = hv_q;
		res_st_d   = res_st_q;
		res_addr_d = res_addr_q;
		rd_addr    = '0;
		sz_we      = 1'b0;
		sz_wa      = g_q;
		sz_wd      = sz_rd;
		fr_we      = 1'b0;
		fr_wa      = g_q;
		fr_wd      = 1'b0;
		ld_out     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					g_d        = '0;
					res_st_d   = ST_OK;
					res_addr_d = '0;
					unique case (req.cmd)
						CMD_ALLOC: begin
							need_d  = rsum[REQ_W-1:2];
							state_d = S_AW;
						end
						CMD_FREE: begin
							if (req.free_addr == '0) begin
								res_st_d = ST_NULL;
								state_d  = S_OUT;
							end else begin
								h_d     = GW'(h8);
								hv_d    = (a8 != '0) && (int'(h8) < NGRAN);
								state_d = S_FM;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_AW: begin
				if (hit) begin
					split_d = split;
					if (split && nb < NGRAN_X) begin
						sz_we = 1'b1;
						sz_wa = nb[GW-1:0];
						sz_wd = sz_rd - GW'(need_q) - GW'(1);
						fr_we = 1'b1;
						fr_wa = nb[GW-1:0];
						fr_wd = 1'b1;
					end
					state_d = S_AS;
				end else if (nxt_a >= NGRAN_X) begin
					res_st_d = ST_NOSPACE;
					state_d  = S_OUT;
				end else begin
					g_d     = nxt_a[GW-1:0];
					rd_addr = nxt_a[GW-1:0];
				end
			end
			S_AS: begin
				sz_we      = split_q;
				sz_wd      = GW'(need_q);
				fr_we      = 1'b1;
				fr_wd      = 1'b0;
				res_addr_d = ADDR_W'({g1, 2'b00});
				state_d    = S_OUT;
			end
			S_FM: begin
				fr_we   = hv_q;
				fr_wa   = h_q;
				fr_wd   = 1'b1;
				state_d = S_F0;
			end
			S_F0: begin
				g_d     = '0;
				state_d = S_FG;
			end
			S_FG: begin
				if (nxt_a >= NGRAN_X) begin
					state_d = S_OUT;
				end else if (fr_rd) begin
					gsz_d   = sz_rd;
					nx_d    = nxt_a[GW-1:0];
					rd_addr = nxt_a[GW-1:0];
					state_d = S_FN;
				end else begin
					g_d     = nxt_a[GW-1:0];
					rd_addr = nxt_a[GW-1:0];
				end
			end
			S_FN: begin
				if (fr_rd) begin
					sz_we = 1'b1;
					sz_wd = merged;
					gsz_d = merged;
					if (nx_m >= NGRAN_X) begin
						state_d = S_OUT;
					end else begin
						nx_d    = nx_m[GW-1:0];
						rd_addr = nx_m[GW-1:0];
					end
				end else if (nxt_n >= NGRAN_X) begin
					state_d = S_OUT;
				end else begin
					g_d     = nxt_n[GW-1:0];
					rd_addr = nxt_n[GW-1:0];
					state_d = S_FG;
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					ld_out  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			sz0_q       <= 1'b1;
			fr0_q       <= 1'b1;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (sz_we && sz_wa == '0) begin
				sz0_q <= 1'b0;
			end
			if (fr_we && fr_wa == '0) begin
				fr0_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ra_s1      <= rd_addr;
		g_q        <= g_d;
		nx_q       <= nx_d;
		gsz_q      <= gsz_d;
		need_q     <= need_d;
		split_q    <= split_d;
		h_q        <= h_d;
		hv_q       <= hv_d;
		res_st_q   <= res_st_d;
		res_addr_q <= res_addr_d;
		if (ld_out) begin
			rsp_st_q   <= res_st_q;
			rsp_addr_q <= res_addr_q;
		end
	end

	`FFHA_ASSERT_NOW(a_walk_in_heap, (state_q == S_AW || state_q == S_FG), int'(g_q) < NGRAN, "walk header beyond heap end")
	`FFHA_ASSERT_NOW(a_merge_no_collide, (state_q == S_FN && sz_we && state_d == S_FN), rd_addr != sz_wa, "merge write hits the entry being read")
	`FFHA_ASSERT_NOW(a_fail_no_addr, (rsp_valid_q && rsp_st_q != ST_OK), rsp_addr_q == '0, "failed item carries an address")
	`FFHA_ASSERT_NEXT(a_load_shows, ld_out, rsp_valid_q && state_q == S_IDLE, "loaded result not presented")
endmodule
